// ----- src/htfc_pkg.sv -----
// Package for the humidity/temperature frame checker: payload structs,
// quality codes, conversion constants and the CRC-8 function.
// Has no dependencies; every other file of the block but htfc_if uses it.
`timescale 1ns / 1ps

package htfc_pkg;

  // Channel codes carried in opcode and channel.
  localparam logic CH_TEMP  = 1'b0;
  localparam logic CH_HUMID = 1'b1;

  typedef enum logic [1:0] {
    QUAL_GOOD      = 2'd0,
    QUAL_BAD_LAST  = 2'd1,
    QUAL_COMM_FAIL = 2'd2
  } quality_t;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [14:0] T_MUL       = 15'd17572;
  localparam logic [14:0] H_MUL       = 15'd12500;
  localparam logic [15:0] T_OFS       = 16'd4685;
  localparam logic [15:0] H_OFS       = 16'd600;
  // floor(x / 10) == (x * 52429) >> 19 for every x below 43690.
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // One received frame as it is registered at the input.
  typedef struct packed {
    logic       opcode;
    logic [7:0] raw_high;
    logic [7:0] raw_low;
    logic [7:0] check_byte;
  } frame_t;

  // After the CRC check and the scaling multiply.
  typedef struct packed {
    logic        channel;
    logic        ok;
    logic [14:0] prod_hi;
  } scaled_t;

  // Offset applied, split into sign and magnitude for the divide by ten.
  typedef struct packed {
    logic        channel;
    logic        ok;
    logic        neg;
    logic [13:0] mag;
  } mag_t;

  // Magnitude of the quotient, sign still separate.
  typedef struct packed {
    logic        channel;
    logic        ok;
    logic        neg;
    logic [10:0] qmag;
  } qmag_t;

  // Finished quotient in two's complement.
  typedef struct packed {
    logic        channel;
    logic        ok;
    logic [11:0] reading;
  } quot_t;

  // MSB-first CRC-8 over one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/htfc_if.sv -----
// Channel interfaces of the frame checker: the frame input and the result output.
// Depends on nothing; ports use plain logic widths.
`timescale 1ns / 1ps

interface htfc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] raw_high;
  logic [7:0] raw_low;
  logic [7:0] check_byte;

  modport source (output valid, output opcode, output raw_high, output raw_low,
                  output check_byte, input ready);
  modport sink   (input valid, input opcode, input raw_high, input raw_low,
                  input check_byte, output ready);
endinterface

interface htfc_out_if;
  logic              valid;
  logic              ready;
  logic              channel;
  logic [1:0]        quality;
  logic signed [11:0] reading;
  logic              check_ok;

  modport source (output valid, output channel, output quality, output reading,
                  output check_ok, input ready);
  modport sink   (input valid, input channel, input quality, input reading,
                  input check_ok, output ready);
endinterface

// ----- src/humidity_temp_frame_checker_top.sv -----
// Top level of the humidity/temperature frame checker.
// Depends on htfc_pkg, htfc_if, htfc_check_scale, htfc_div10 and htfc_store.
//
//   Port     Direction  Transaction
//   frame    sink       opcode, raw_high, raw_low, check_byte
//   result   source     channel, quality, reading, check_ok
//
// One frame is taken every cycle while the output is not stalled; its result
// reaches the output register through the CRC/multiply, offset, reciprocal
// multiply and store stages. Synchronous reset empties every stage and sets both
// channels to communication failure with a reading of zero. A stalled output
// lets the four stages behind it fill before frame.ready falls.
`timescale 1ns / 1ps

module humidity_temp_frame_checker_top (
  input  logic       clk,
  input  logic       rst,
  htfc_in_if.sink    frame,
  htfc_out_if.source result
);

  logic            mag_valid;
  logic            mag_ready;
  htfc_pkg::mag_t  mag;
  logic            quot_valid;
  logic            quot_ready;
  htfc_pkg::quot_t quot;

  htfc_check_scale u_check_scale (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .mag_valid (mag_valid),
    .mag_ready (mag_ready),
    .mag       (mag)
  );

  htfc_div10 u_div10 (
    .clk        (clk),
    .rst        (rst),
    .mag_valid  (mag_valid),
    .mag_ready  (mag_ready),
    .mag        (mag),
    .quot_valid (quot_valid),
    .quot_ready (quot_ready),
    .quot       (quot)
  );

  htfc_store u_store (
    .clk        (clk),
    .rst        (rst),
    .quot_valid (quot_valid),
    .quot_ready (quot_ready),
    .quot       (quot),
    .result     (result)
  );

endmodule

// ----- src/htfc_check_scale.sv -----
// Input register, CRC-8 check and scaling multiply, then offset and sign split.
// Depends on htfc_pkg and htfc_in_if.
`timescale 1ns / 1ps

module htfc_check_scale (
  input  logic           clk,
  input  logic           rst,
  htfc_in_if.sink        frame,
  output logic           mag_valid,
  input  logic           mag_ready,
  output htfc_pkg::mag_t mag
);

  logic                 a_valid;
  logic                 a_ready;
  htfc_pkg::frame_t     a_frame;
  logic                 b_valid;
  logic                 b_ready;
  htfc_pkg::scaled_t    b_data;
  htfc_pkg::scaled_t    b_next;
  logic [15:0]          raw;
  logic [7:0]           crc;
  logic [14:0]          mul;
  logic [30:0]          prod;
  logic [15:0]          ofs;
  logic signed [15:0]   diff;
  logic [15:0]          absval;

  // A stage may load whenever it is empty or its contents move on.
  assign b_ready     = !b_valid || mag_ready;
  assign a_ready     = !a_valid || b_ready;
  assign frame.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && frame.valid) begin
      a_frame <= '{opcode: frame.opcode, raw_high: frame.raw_high,
                   raw_low: frame.raw_low, check_byte: frame.check_byte};
    end
  end

  always_comb begin
    raw            = {a_frame.raw_high, a_frame.raw_low};
    crc            = htfc_pkg::crc8_byte(htfc_pkg::crc8_byte(8'h00, a_frame.raw_high),
                                         a_frame.raw_low);
    mul            = (a_frame.opcode == htfc_pkg::CH_HUMID) ? htfc_pkg::H_MUL : htfc_pkg::T_MUL;
    prod           = 31'(raw) * 31'(mul);
    b_next.channel = a_frame.opcode;
    b_next.ok      = (crc == a_frame.check_byte);
    b_next.prod_hi = prod[30:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_data <= b_next;
    end
  end

  // The scaled value lies in -4685..12886, so its magnitude fits in 14 bits.
  always_comb begin
    ofs         = (b_data.channel == htfc_pkg::CH_HUMID) ? htfc_pkg::H_OFS : htfc_pkg::T_OFS;
    diff        = $signed({1'b0, b_data.prod_hi}) - $signed(ofs);
    absval      = diff[15] ? 16'(-diff) : 16'(diff);
    mag.channel = b_data.channel;
    mag.ok      = b_data.ok;
    mag.neg     = diff[15];
    mag.mag     = absval[13:0];
  end

  assign mag_valid = b_valid;

endmodule

// ----- src/htfc_div10.sv -----
// Divide by ten, truncating toward zero, by a reciprocal multiply on the magnitude.
// Depends on htfc_pkg.
`timescale 1ns / 1ps

module htfc_div10 (
  input  logic            clk,
  input  logic            rst,
  input  logic            mag_valid,
  output logic            mag_ready,
  input  htfc_pkg::mag_t  mag,
  output logic            quot_valid,
  input  logic            quot_ready,
  output htfc_pkg::quot_t quot
);

  logic             c_valid;
  logic             c_ready;
  htfc_pkg::mag_t   c_data;
  logic             d_valid;
  logic             d_ready;
  htfc_pkg::qmag_t  d_data;
  htfc_pkg::qmag_t  d_next;
  logic [29:0]      prod;
  logic [11:0]      q12;

  assign d_ready   = !d_valid || quot_ready;
  assign c_ready   = !c_valid || d_ready;
  assign mag_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && mag_valid) begin
      c_data <= mag;
    end
  end

  always_comb begin
    prod           = 30'(c_data.mag) * 30'(htfc_pkg::DIV10_RECIP);
    d_next.channel = c_data.channel;
    d_next.ok      = c_data.ok;
    d_next.neg     = c_data.neg;
    d_next.qmag    = prod[htfc_pkg::DIV10_SHIFT +: 11];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      d_data <= d_next;
    end
  end

  always_comb begin
    q12          = {1'b0, d_data.qmag};
    quot.channel = d_data.channel;
    quot.ok      = d_data.ok;
    quot.reading = d_data.neg ? 12'(-q12) : q12;
  end

  assign quot_valid = d_valid;

endmodule

// ----- src/htfc_store.sv -----
// Per-channel quality and reading store, plus the result register.
// Depends on htfc_pkg and htfc_out_if.
`timescale 1ns / 1ps

module htfc_store (
  input  logic            clk,
  input  logic            rst,
  input  logic            quot_valid,
  output logic            quot_ready,
  input  htfc_pkg::quot_t quot,
  htfc_out_if.source      result
);

  htfc_pkg::quality_t quality_st [2];
  logic [11:0]        reading_st [2];
  htfc_pkg::quality_t qual_next;
  logic [11:0]        read_next;
  logic               out_valid;
  logic               load;

  assign quot_ready = !out_valid || result.ready;
  assign load       = quot_valid && quot_ready;

  // A failed check demotes a good channel; other qualities stand.
  always_comb begin
    if (quot.ok) begin
      qual_next = htfc_pkg::QUAL_GOOD;
      read_next = quot.reading;
    end else begin
      qual_next = (quality_st[quot.channel] == htfc_pkg::QUAL_GOOD) ?
                  htfc_pkg::QUAL_BAD_LAST : quality_st[quot.channel];
      read_next = reading_st[quot.channel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_st[0] <= htfc_pkg::QUAL_COMM_FAIL;
      quality_st[1] <= htfc_pkg::QUAL_COMM_FAIL;
      reading_st[0] <= '0;
      reading_st[1] <= '0;
    end else if (load) begin
      quality_st[quot.channel] <= qual_next;
      reading_st[quot.channel] <= read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (quot_ready) begin
      out_valid <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.channel  <= quot.channel;
      result.quality  <= qual_next;
      result.reading  <= $signed(read_next);
      result.check_ok <= quot.ok;
    end
  end

  assign result.valid = out_valid;

endmodule
